// ===== src/sktup_pkg.sv =====
`default_nettype none
package sktup_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 32;

  // Fixed field widths
  localparam int KEY_W = 16;
  localparam int TAG_W = 64;
  localparam int DATE_W = 16;
  localparam int RC_W = 6;

  // Operation codes
  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_PURGE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  // Cell load modes
  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_LOAD = 2'd1;
  localparam logic [1:0] CM_LEFT = 2'd2;
  localparam logic [1:0] CM_RIGHT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [DATE_W-1:0] date;
  } entry_t;

  // Compare results reported by each cell
  typedef struct packed {
    logic lt;
    logic eq;
    logic hit;
  } cell_flags_t;

endpackage
`default_nettype wire

// ===== src/sktup_cell.sv =====
`default_nettype none
module sktup_cell
  import sktup_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [1:0]  mode,
  input  wire logic        occ,
  input  wire entry_t      fresh,
  input  wire entry_t      probe,
  input  wire entry_t      left,
  input  wire entry_t      right,
  output entry_t           data,
  output cell_flags_t      flags
);

  // Compare the held entry against the probe word
  always_comb begin
    flags.lt = occ && (data.key < probe.key);
    flags.eq = occ && (data.key == probe.key);
    flags.hit = occ && (data.date == probe.date);
  end

  // Load, take from a neighbour, or hold
  always_ff @(posedge clk) begin
    case (mode)
      CM_LOAD: data <= fresh;
      CM_LEFT: data <= left;
      CM_RIGHT: data <= right;
      default: data <= data;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sorted_key_table_upsert_purge.sv =====
// Upsert and clear: result in the cycle after accept, busy never raised.
// Purge: one entry leaves the chain per cycle until no stored date matches;
//   result on the cycle after the last compare.
// Dump: the cell ring rotates once while busy, entries appear one per cycle from
//   cell 0; an empty table strobes without busy. Results cannot be stalled.
// Reset empties the table (count cleared); entry contents are not cleared.
`default_nettype none
module sorted_key_table_upsert_purge
  import sktup_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        operation,
  input  wire logic [KEY_W-1:0]  room,
  input  wire logic [TAG_W-1:0]  name_tag,
  input  wire logic [DATE_W-1:0] checkout_date,
  output logic                   strobe,
  output logic [KEY_W-1:0]       out_room,
  output logic [TAG_W-1:0]       out_name_tag,
  output logic [DATE_W-1:0]      out_checkout_date,
  output logic                   entry_valid,
  output logic                   last,
  output logic                   status,
  output logic [RC_W-1:0]        removed_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PURGE = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     removed;
  logic [SW-1:0]     step;
  logic [DATE_W-1:0] purge_date;

  entry_t            fresh;
  entry_t            probe;
  entry_t            cell_data [CAPACITY];
  cell_flags_t       cell_flags [CAPACITY];
  logic [1:0]        cell_mode [CAPACITY];
  logic              cell_occ [CAPACITY];

  logic              any_eq;
  logic              any_hit;
  logic              full;
  logic              upsert_go;

  assign busy = (state != ST_IDLE);
  assign full = (count == CW'(CAPACITY));
  assign upsert_go = (state == ST_IDLE) && start && (operation == OP_UPSERT);

  // Broadcast words for the chain
  always_comb begin
    fresh.key = room;
    fresh.tag = name_tag;
    fresh.date = checkout_date;
    if (state == ST_IDLE) begin
      probe = fresh;
    end else begin
      probe.key = '0;
      probe.tag = '0;
      probe.date = purge_date;
    end
  end

  // Chain of cells, ring-closed at the far end
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign cell_occ[g] = (CW'(g) < count);
    sktup_cell u_cell (
      .clk   (clk),
      .mode  (cell_mode[g]),
      .occ   (cell_occ[g]),
      .fresh (fresh),
      .probe (probe),
      .left  ((g == 0) ? fresh : cell_data[(g == 0) ? 0 : g - 1]),
      .right (cell_data[(g == CAPACITY - 1) ? 0 : g + 1]),
      .data  (cell_data[g]),
      .flags (cell_flags[g])
    );
  end

  // Combine cell flags and pick each cell's load mode
  always_comb begin
    logic below_prev;
    logic after;
    any_eq = 1'b0;
    any_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq = any_eq | cell_flags[i].eq;
      any_hit = any_hit | cell_flags[i].hit;
    end
    below_prev = 1'b0;
    after = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_mode[i] = CM_HOLD;
      after = after | cell_flags[i].hit;
      if (upsert_go) begin
        if (any_eq) begin
          if (cell_flags[i].eq) begin
            cell_mode[i] = CM_LOAD;
          end
        end else if (!full) begin
          if (!cell_flags[i].lt && !below_prev) begin
            cell_mode[i] = CM_LOAD;
          end else if (below_prev && (CW'(i) <= count)) begin
            cell_mode[i] = CM_LEFT;
          end
        end
      end else if (state == ST_PURGE) begin
        if (after) begin
          cell_mode[i] = CM_RIGHT;
        end
      end else if (state == ST_DUMP) begin
        cell_mode[i] = CM_RIGHT;
      end
      below_prev = !cell_flags[i].lt;
    end
  end

  // Sequencer and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      removed <= '0;
      step <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            out_room <= '0;
            out_name_tag <= '0;
            out_checkout_date <= '0;
            entry_valid <= 1'b0;
            last <= 1'b1;
            status <= 1'b0;
            removed_count <= '0;
            case (operation)
              OP_UPSERT: begin
                strobe <= 1'b1;
                status <= !any_eq && full;
                if (!any_eq && !full) begin
                  count <= count + CW'(1);
                end
              end
              OP_PURGE: begin
                purge_date <= checkout_date;
                removed <= '0;
                state <= ST_PURGE;
              end
              OP_CLEAR: begin
                strobe <= 1'b1;
                removed_count <= RC_W'(count);
                count <= '0;
              end
              default: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                end else begin
                  step <= '0;
                  state <= ST_DUMP;
                end
              end
            endcase
          end
        end
        ST_PURGE: begin
          if (any_hit) begin
            count <= count - CW'(1);
            removed <= removed + CW'(1);
          end else begin
            strobe <= 1'b1;
            removed_count <= RC_W'(removed);
            state <= ST_IDLE;
          end
        end
        ST_DUMP: begin
          if (CW'(step) < count) begin
            strobe <= 1'b1;
            out_room <= cell_data[0].key;
            out_name_tag <= cell_data[0].tag;
            out_checkout_date <= cell_data[0].date;
            entry_valid <= 1'b1;
            last <= (CW'(step) == count - CW'(1));
            status <= 1'b0;
            removed_count <= '0;
          end
          step <= step + SW'(1);
          if (step == SW'(CAPACITY - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_upsert_result: assert property (@(posedge clk) disable iff (rst)
    upsert_go |=> strobe && last && !entry_valid && !busy)
    else $error("upsert gave no single result");

  a_purge_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PURGE) && !any_hit |=> strobe && last && (state == ST_IDLE))
    else $error("purge did not finish");

  a_dump_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) && (step == SW'(CAPACITY - 1)) |=> (state == ST_IDLE))
    else $error("dump did not complete one rotation");

  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && entry_valid |-> !status && (removed_count == '0))
    else $error("entry word carries status");

endmodule
`default_nettype wire
